FILE: hw/rtl/wfd_pkg.sv
package wfd_pkg;

    // Field widths
    localparam int PROX_BITS  = 11;
    localparam int SPEED_BITS = 16;
    localparam int TOF_BITS   = 13;

    // Configuration register widths
    localparam int CT_W       = 10;
    localparam int DD_W       = 10;
    localparam int MS_W       = 15;
    localparam int MIN_W      = 15;
    localparam int ANG_W      = 10;
    localparam int AF_W       = 16;
    localparam int TG_W       = 16;
    localparam int ST_W       = 15;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    // Fixed-point scaling
    localparam int AF_FRAC   = 15;
    localparam int TURN_FRAC = 4;

    // Derived datapath widths
    localparam int ERR_BITS  = ((PROX_BITS > DD_W + 1) ? PROX_BITS : DD_W + 1) + 1;
    localparam int DIFF_BITS = ERR_BITS + 1;
    localparam int MUL_W     = (ERR_BITS > AF_W + 1) ? ERR_BITS : AF_W + 1;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int TURN_BITS = TG_W + ERR_BITS - TURN_FRAC;
    localparam int NUM_W     = MS_W + ANG_W;
    localparam int SCALED_W  = MS_W + AF_W - AF_FRAC;
    localparam int SUM_BASE  = ((TURN_BITS > SCALED_W + 1) ? TURN_BITS : SCALED_W + 1) + 1;
    localparam int SUM_W     = (SUM_BASE > SPEED_BITS + 1) ? SUM_BASE : SPEED_BITS + 1;
    localparam int CMP_W     = ((SPEED_BITS > ST_W + 1) ? SPEED_BITS : ST_W + 1) + 1;
    localparam int DIV_STEPS = NUM_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // Register reset values
    localparam logic [CT_W-1:0]         CT_RESET  = CT_W'(200);
    localparam logic [DD_W-1:0]         DD_RESET  = DD_W'(300);
    localparam logic [MS_W-1:0]         MS_RESET  = MS_W'(25600);
    localparam logic [MIN_W-1:0]        MIN_RESET = MIN_W'(5120);
    localparam logic [ANG_W-1:0]        ANG_RESET = ANG_W'(200);
    localparam logic [AF_W-1:0]         AF_RESET  = AF_W'(16384);
    localparam logic signed [TG_W-1:0]  TG_RESET  = TG_W'(410);
    localparam logic [ST_W-1:0]         ST_RESET  = ST_W'(256);

    typedef enum logic [1:0] {
        MODE_TICK   = 2'd0,
        MODE_ENTER  = 2'd1,
        MODE_EXIT   = 2'd2,
        MODE_UNUSED = 2'd3
    } wfd_mode_t;

    typedef enum logic [1:0] {
        PH_START    = 2'd0,
        PH_FOLLOW   = 2'd1,
        PH_STOPPING = 2'd2,
        PH_OFF      = 2'd3
    } wfd_phase_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CORNER_THRESHOLD = 3'd0,
        CFG_DESIRED_DISTANCE = 3'd1,
        CFG_MAX_SPEED        = 3'd2,
        CFG_MIN_SPEED        = 3'd3,
        CFG_MAX_SPEED_ANGLE  = 3'd4,
        CFG_APPROACH_FACTOR  = 3'd5,
        CFG_TURN_GAIN        = 3'd6,
        CFG_STOP_THRESHOLD   = 3'd7
    } wfd_cfg_idx_t;

    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_TURN  = 2'd1,
        OP_NUM   = 2'd2,
        OP_SCALE = 2'd3
    } wfd_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVAL,
        ST_TURN,
        ST_NUM,
        ST_DIV,
        ST_CLAMP,
        ST_SCALE,
        ST_SUM,
        ST_OUT
    } wfd_state_t;

    typedef struct packed {
        logic [CT_W-1:0]        corner_threshold;
        logic [DD_W-1:0]        desired_distance;
        logic [MS_W-1:0]        max_speed;
        logic [MIN_W-1:0]       min_speed;
        logic [ANG_W-1:0]       max_speed_angle;
        logic [AF_W-1:0]        approach_factor;
        logic signed [TG_W-1:0] turn_gain;
        logic [ST_W-1:0]        stop_threshold;
    } wfd_cfg_t;

    // Controller to datapath
    typedef struct packed {
        logic    load;
        wfd_op_t op;
        logic    div_step;
        logic    clamp;
        logic    sum;
        logic    side_right;
    } wfd_cmd_t;

    // Datapath to controller
    typedef struct packed {
        wfd_mode_t mode;
        logic      any_pos;
        logic      pick_right;
        logic      corner_ahead;
        logic      stopped;
    } wfd_stat_t;

    // Controller result flags
    typedef struct packed {
        logic       drive_write;
        logic       use_speed;
        logic       following_right;
        logic       corner_detected;
        logic       running_led;
        wfd_phase_t phase;
    } wfd_res_t;

endpackage

FILE: hw/rtl/wfd_in_if.sv
interface wfd_in_if import wfd_pkg::*;;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   mode;
    logic signed [PROX_BITS-1:0]  prox_left;
    logic signed [PROX_BITS-1:0]  prox_right;
    logic signed [PROX_BITS-1:0]  prox_front;
    logic signed [PROX_BITS-1:0]  prox_front_left;
    logic signed [PROX_BITS-1:0]  prox_front_right;
    logic [TOF_BITS-1:0]          tof_center;
    logic signed [SPEED_BITS-1:0] measured_left;
    logic signed [SPEED_BITS-1:0] measured_right;

    modport source (
        output valid, mode, prox_left, prox_right, prox_front, prox_front_left,
               prox_front_right, tof_center, measured_left, measured_right,
        input  ready
    );

    modport sink (
        input  valid, mode, prox_left, prox_right, prox_front, prox_front_left,
               prox_front_right, tof_center, measured_left, measured_right,
        output ready
    );
endinterface

FILE: hw/rtl/wfd_out_if.sv
interface wfd_out_if import wfd_pkg::*;;
    logic                         valid;
    logic                         ready;
    logic signed [SPEED_BITS-1:0] speed_left;
    logic signed [SPEED_BITS-1:0] speed_right;
    logic                         drive_write;
    logic                         following_right;
    logic                         corner_detected;
    logic                         running_led;
    logic [1:0]                   phase;

    modport source (
        output valid, speed_left, speed_right, drive_write, following_right,
               corner_detected, running_led, phase,
        input  ready
    );

    modport sink (
        input  valid, speed_left, speed_right, drive_write, following_right,
               corner_detected, running_led, phase,
        output ready
    );
endinterface

FILE: hw/rtl/wall_following_drive_controller_unit.sv
// An accepted item is captured and evaluated; a driving follow tick then runs turn,
// numerator, a division loop of 25 steps, clamp, scale and sum. One item at a time: the
// result is registered once the output register has space, the input is ready again in the
// cycle after that, and the next item runs while the output register holds the previous
// result. Reset: asynchronous, active low; start phase, left wall, flags cleared,
// configuration registers at their defaults, no result pending.
module wall_following_drive_controller_unit import wfd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    wfd_in_if.sink                in_ch,
    wfd_out_if.source             out_ch
);

    wfd_cfg_t                     cfg;
    wfd_cmd_t                     cmd;
    wfd_stat_t                    stat;
    wfd_res_t                     res;
    logic                         out_load;
    logic                         out_space;
    logic signed [SPEED_BITS-1:0] dp_speed_left;
    logic signed [SPEED_BITS-1:0] dp_speed_right;

    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic signed [SPEED_BITS-1:0] out_sl_reg;
    logic signed [SPEED_BITS-1:0] out_sr_reg;
    wfd_res_t                     out_res_reg;

    wfd_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    wfd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .out_space (out_space),
        .stat      (stat),
        .in_ready  (in_ch.ready),
        .out_load  (out_load),
        .cmd       (cmd),
        .res       (res)
    );

    wfd_datapath u_datapath (
        .clk              (clk),
        .cmd              (cmd),
        .cfg              (cfg),
        .mode             (in_ch.mode),
        .prox_left        (in_ch.prox_left),
        .prox_right       (in_ch.prox_right),
        .prox_front       (in_ch.prox_front),
        .prox_front_left  (in_ch.prox_front_left),
        .prox_front_right (in_ch.prox_front_right),
        .tof_center       (in_ch.tof_center),
        .measured_left    (in_ch.measured_left),
        .measured_right   (in_ch.measured_right),
        .stat             (stat),
        .speed_left       (dp_speed_left),
        .speed_right      (dp_speed_right)
    );

    // Output register: free when empty or being drained
    assign out_space = !out_valid_reg || out_ch.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ch.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // Load the result item; speeds are zero unless the datapath drove them
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_sl_reg  <= res.use_speed ? dp_speed_left : '0;
            out_sr_reg  <= res.use_speed ? dp_speed_right : '0;
            out_res_reg <= res;
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.speed_left      = out_sl_reg;
    assign out_ch.speed_right     = out_sr_reg;
    assign out_ch.drive_write     = out_res_reg.drive_write;
    assign out_ch.following_right = out_res_reg.following_right;
    assign out_ch.corner_detected = out_res_reg.corner_detected;
    assign out_ch.running_led     = out_res_reg.running_led;
    assign out_ch.phase           = out_res_reg.phase;

    // One item in flight at a time
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
        else $error("input accepted while an item is in flight");

    // A pending result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || out_ch.ready))
        else $error("result register overwritten");

    // Without a drive write the speeds are zero
    a_zero_speed: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ch.drive_write) |->
        (out_ch.speed_left == '0 && out_ch.speed_right == '0))
        else $error("speeds present without a drive write");

    // The off phase is reached only through a detected corner
    a_off_corner: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_ch.phase == PH_OFF) |-> out_ch.corner_detected)
        else $error("off phase without corner flag");

endmodule

FILE: hw/rtl/wfd_cfg_regs.sv
module wfd_cfg_regs import wfd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output wfd_cfg_t              cfg
);

    wfd_cfg_t cfg_reg;
    wfd_cfg_t cfg_next;

    // Decode the register write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (wfd_cfg_idx_t'(cfg_index))
                CFG_CORNER_THRESHOLD: cfg_next.corner_threshold = cfg_data[CT_W-1:0];
                CFG_DESIRED_DISTANCE: cfg_next.desired_distance = cfg_data[DD_W-1:0];
                CFG_MAX_SPEED:        cfg_next.max_speed        = cfg_data[MS_W-1:0];
                CFG_MIN_SPEED:        cfg_next.min_speed        = cfg_data[MIN_W-1:0];
                CFG_MAX_SPEED_ANGLE:  cfg_next.max_speed_angle  = cfg_data[ANG_W-1:0];
                CFG_APPROACH_FACTOR:  cfg_next.approach_factor  = cfg_data[AF_W-1:0];
                CFG_TURN_GAIN:        cfg_next.turn_gain        = $signed(cfg_data[TG_W-1:0]);
                CFG_STOP_THRESHOLD:   cfg_next.stop_threshold   = cfg_data[ST_W-1:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.corner_threshold <= CT_RESET;
            cfg_reg.desired_distance <= DD_RESET;
            cfg_reg.max_speed        <= MS_RESET;
            cfg_reg.min_speed        <= MIN_RESET;
            cfg_reg.max_speed_angle  <= ANG_RESET;
            cfg_reg.approach_factor  <= AF_RESET;
            cfg_reg.turn_gain        <= TG_RESET;
            cfg_reg.stop_threshold   <= ST_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hw/rtl/wfd_datapath.sv
module wfd_datapath import wfd_pkg::*;
(
    input  logic                         clk,
    input  wfd_cmd_t                     cmd,
    input  wfd_cfg_t                     cfg,
    input  logic [1:0]                   mode,
    input  logic signed [PROX_BITS-1:0]  prox_left,
    input  logic signed [PROX_BITS-1:0]  prox_right,
    input  logic signed [PROX_BITS-1:0]  prox_front,
    input  logic signed [PROX_BITS-1:0]  prox_front_left,
    input  logic signed [PROX_BITS-1:0]  prox_front_right,
    input  logic [TOF_BITS-1:0]          tof_center,
    input  logic signed [SPEED_BITS-1:0] measured_left,
    input  logic signed [SPEED_BITS-1:0] measured_right,
    output wfd_stat_t                    stat,
    output logic signed [SPEED_BITS-1:0] speed_left,
    output logic signed [SPEED_BITS-1:0] speed_right
);

    localparam logic signed [SUM_W-1:0] SPD_MAX =
        SUM_W'((64'sd1 <<< (SPEED_BITS - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] SPD_MIN =
        SUM_W'(-(64'sd1 <<< (SPEED_BITS - 1)));

    // Captured item
    logic [1:0]                   mode_reg;
    logic signed [PROX_BITS-1:0]  pl_reg;
    logic signed [PROX_BITS-1:0]  pr_reg;
    logic signed [PROX_BITS-1:0]  pf_reg;
    logic signed [PROX_BITS-1:0]  pfl_reg;
    logic signed [PROX_BITS-1:0]  pfr_reg;
    logic                         tof_nz_reg;
    logic signed [SPEED_BITS-1:0] ml_reg;
    logic signed [SPEED_BITS-1:0] mr_reg;

    // Working registers
    logic signed [TURN_BITS-1:0]  turn_reg;
    logic signed [DIFF_BITS-1:0]  diff_reg;
    logic [NUM_W-1:0]             quo_reg;
    logic [ANG_W-1:0]             rem_reg;
    logic [MS_W-1:0]              fwd_reg;
    logic [SCALED_W-1:0]          scaled_reg;
    logic signed [SPEED_BITS-1:0] sl_reg;
    logic signed [SPEED_BITS-1:0] sr_reg;

    logic [ANG_W-1:0]             ang;
    logic signed [PROX_BITS-1:0]  side_prox;
    logic signed [ERR_BITS-1:0]   side_ext;
    logic signed [ERR_BITS-1:0]   dd_ext;
    logic signed [ERR_BITS-1:0]   err;
    logic [ERR_BITS-1:0]          aerr;
    logic signed [DIFF_BITS-1:0]  diff;
    logic [ANG_W-1:0]             num_diff;

    logic signed [MUL_W-1:0]      mul_a;
    logic signed [MUL_W-1:0]      mul_b;
    logic signed [PROD_W-1:0]     prod;

    logic [ANG_W:0]               trial;
    logic                         trial_ge;
    logic [ANG_W-1:0]             rem_next;

    logic [NUM_W-1:0]             raised;
    logic [NUM_W-1:0]             lowered;
    logic [MS_W-1:0]              fwd_next;
    logic [SCALED_W-1:0]          scaled_next;

    logic signed [SUM_W-1:0]      scaled_ext;
    logic signed [SUM_W-1:0]      turn_ext;
    logic signed [SPEED_BITS-1:0] near_spd;
    logic signed [SPEED_BITS-1:0] far_spd;

    logic signed [ERR_BITS-1:0]   pf_ext;
    logic signed [ERR_BITS-1:0]   ct_ext;
    logic signed [CMP_W-1:0]      ml_ext;
    logic signed [CMP_W-1:0]      mr_ext;
    logic signed [CMP_W-1:0]      st_ext;

    function automatic logic signed [SPEED_BITS-1:0] sat_speed(
        input logic signed [SUM_W-1:0] v
    );
        logic signed [SUM_W-1:0] c;
        begin
            if (v > SPD_MAX)
                c = SPD_MAX;
            else if (v < SPD_MIN)
                c = SPD_MIN;
            else
                c = v;
            return c[SPEED_BITS-1:0];
        end
    endfunction

    // Status towards the controller
    assign pf_ext = ERR_BITS'(pf_reg);
    assign ct_ext = $signed(ERR_BITS'(cfg.corner_threshold));
    assign ml_ext = CMP_W'(ml_reg);
    assign mr_ext = CMP_W'(mr_reg);
    assign st_ext = $signed(CMP_W'(cfg.stop_threshold));

    assign stat.mode         = wfd_mode_t'(mode_reg);
    assign stat.any_pos      = (!pl_reg[PROX_BITS-1] && (pl_reg != '0)) ||
                               (!pr_reg[PROX_BITS-1] && (pr_reg != '0));
    assign stat.pick_right   = pr_reg > pl_reg;
    assign stat.corner_ahead = pf_ext > ct_ext;
    assign stat.stopped      = (ml_ext < st_ext) && (mr_ext < st_ext);

    // Wall error and remaining angle margin
    assign ang       = (cfg.max_speed_angle == '0) ? ANG_W'(1) : cfg.max_speed_angle;
    assign side_prox = cmd.side_right ? pfr_reg : pfl_reg;
    assign side_ext  = ERR_BITS'(side_prox);
    assign dd_ext    = $signed(ERR_BITS'(cfg.desired_distance));
    assign err       = side_ext - dd_ext;
    assign aerr      = err[ERR_BITS-1] ? ERR_BITS'(-err) : ERR_BITS'(err);
    assign diff      = $signed(DIFF_BITS'(ang)) - $signed(DIFF_BITS'(aerr));
    // A margin at or below zero drives forward speed to the lower bound
    assign num_diff  = (diff_reg > 0) ? diff_reg[ANG_W-1:0] : '0;

    // Shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_TURN:
            begin
                mul_a = MUL_W'(cfg.turn_gain);
                mul_b = MUL_W'(err);
            end
            OP_NUM:
            begin
                mul_a = $signed(MUL_W'(cfg.max_speed));
                mul_b = $signed(MUL_W'(num_diff));
            end
            OP_SCALE:
            begin
                mul_a = $signed(MUL_W'(fwd_reg));
                mul_b = $signed(MUL_W'(cfg.approach_factor));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // One restoring division step per cycle
    assign trial    = {rem_reg, quo_reg[NUM_W-1]};
    assign trial_ge = trial >= {1'b0, ang};
    assign rem_next = trial_ge ? ANG_W'(trial - {1'b0, ang}) : ANG_W'(trial);

    // Raise to the lower bound, then lower to the upper bound
    assign raised   = (quo_reg < NUM_W'(cfg.min_speed)) ? NUM_W'(cfg.min_speed) : quo_reg;
    assign lowered  = (raised > NUM_W'(cfg.max_speed)) ? NUM_W'(cfg.max_speed) : raised;
    assign fwd_next = lowered[MS_W-1:0];

    assign scaled_next = tof_nz_reg ? prod[AF_FRAC +: SCALED_W] : SCALED_W'(fwd_reg);

    // Wheel sums
    assign scaled_ext = $signed(SUM_W'(scaled_reg));
    assign turn_ext   = SUM_W'(turn_reg);
    assign near_spd   = sat_speed(scaled_ext + turn_ext);
    assign far_spd    = sat_speed(scaled_ext - turn_ext);

    // Capture and advance the working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg   <= mode;
            pl_reg     <= prox_left;
            pr_reg     <= prox_right;
            pf_reg     <= prox_front;
            pfl_reg    <= prox_front_left;
            pfr_reg    <= prox_front_right;
            tof_nz_reg <= tof_center != '0;
            ml_reg     <= measured_left;
            mr_reg     <= measured_right;
        end

        case (cmd.op)
            OP_TURN:
            begin
                turn_reg <= $signed(prod[TURN_FRAC +: TURN_BITS]);
                diff_reg <= diff;
            end
            OP_NUM:
            begin
                quo_reg <= prod[NUM_W-1:0];
                rem_reg <= '0;
            end
            OP_SCALE:
            begin
                scaled_reg <= scaled_next;
            end
            default:
            begin
                turn_reg <= turn_reg;
            end
        endcase

        if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[NUM_W-2:0], trial_ge};
        end

        if (cmd.clamp)
            fwd_reg <= fwd_next;

        if (cmd.sum)
        begin
            sl_reg <= cmd.side_right ? far_spd : near_spd;
            sr_reg <= cmd.side_right ? near_spd : far_spd;
        end
    end

    assign speed_left  = sl_reg;
    assign speed_right = sr_reg;

endmodule

FILE: hw/rtl/wfd_ctrl.sv
module wfd_ctrl import wfd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      out_space,
    input  wfd_stat_t stat,
    output logic      in_ready,
    output logic      out_load,
    output wfd_cmd_t  cmd,
    output wfd_res_t  res
);

    wfd_state_t       state_reg,  state_next;
    wfd_phase_t       phase_reg,  phase_next;
    logic             side_reg,   side_next;
    logic             corner_reg, corner_next;
    logic             led_reg,    led_next;
    logic             wr_reg,     wr_next;
    logic             spd_reg,    spd_next;
    logic [CNT_W-1:0] cnt_reg,    cnt_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            phase_reg  <= PH_START;
            side_reg   <= 1'b0;
            corner_reg <= 1'b0;
            led_reg    <= 1'b0;
            wr_reg     <= 1'b0;
            spd_reg    <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            side_reg   <= side_next;
            corner_reg <= corner_next;
            led_reg    <= led_next;
            wr_reg     <= wr_next;
            spd_reg    <= spd_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        side_next      = side_reg;
        corner_next    = corner_reg;
        led_next       = led_reg;
        wr_next        = wr_reg;
        spd_next       = spd_reg;
        cnt_next       = cnt_reg;
        in_ready       = 1'b0;
        out_load       = 1'b0;
        cmd            = '0;
        cmd.op         = OP_NONE;
        cmd.side_right = side_reg;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EVAL;
                end
            end

            ST_EVAL:
            begin
                wr_next    = 1'b0;
                spd_next   = 1'b0;
                state_next = ST_OUT;
                case (stat.mode)
                    MODE_ENTER:
                    begin
                        led_next   = 1'b1;
                        phase_next = PH_START;
                    end
                    MODE_EXIT:
                    begin
                        led_next = 1'b0;
                        wr_next  = 1'b1;
                    end
                    MODE_TICK:
                    begin
                        case (phase_reg)
                            PH_START:
                            begin
                                if (stat.any_pos)
                                begin
                                    side_next  = stat.pick_right;
                                    wr_next    = 1'b1;
                                    phase_next = PH_FOLLOW;
                                end
                            end
                            PH_FOLLOW:
                            begin
                                wr_next = 1'b1;
                                if (stat.corner_ahead)
                                    phase_next = PH_STOPPING;
                                else
                                begin
                                    spd_next   = 1'b1;
                                    state_next = ST_TURN;
                                end
                            end
                            PH_STOPPING:
                            begin
                                if (stat.stopped)
                                begin
                                    corner_next = 1'b1;
                                    phase_next  = PH_OFF;
                                end
                            end
                            default:
                            begin
                                phase_next = phase_reg;
                            end
                        endcase
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end

            ST_TURN:
            begin
                cmd.op     = OP_TURN;
                state_next = ST_NUM;
            end

            ST_NUM:
            begin
                cmd.op     = OP_NUM;
                cnt_next   = '0;
                state_next = ST_DIV;
            end

            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                    state_next = ST_CLAMP;
            end

            ST_CLAMP:
            begin
                cmd.clamp  = 1'b1;
                state_next = ST_SCALE;
            end

            ST_SCALE:
            begin
                cmd.op     = OP_SCALE;
                state_next = ST_SUM;
            end

            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = ST_OUT;
            end

            ST_OUT:
            begin
                if (out_space)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res.drive_write     = wr_reg;
    assign res.use_speed       = spd_reg;
    assign res.following_right = side_reg;
    assign res.corner_detected = corner_reg;
    assign res.running_led     = led_reg;
    assign res.phase           = phase_reg;

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top import wfd_pkg::*;;

    localparam int CLK_HALF    = 5;
    localparam int PHASE_ITEMS = 320;
    localparam int REG_PHASES  = 6;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 10;
    localparam int SETTLE      = 4;
    localparam int TAIL_CYCLES = 40;

    typedef struct {
        wfd_mode_t                    mode;
        logic signed [PROX_BITS-1:0]  left;
        logic signed [PROX_BITS-1:0]  right;
        logic signed [PROX_BITS-1:0]  front;
        logic signed [PROX_BITS-1:0]  front_left;
        logic signed [PROX_BITS-1:0]  front_right;
        logic [TOF_BITS-1:0]          tof;
        logic signed [SPEED_BITS-1:0] meas_left;
        logic signed [SPEED_BITS-1:0] meas_right;
    } tick_t;

    typedef struct {
        logic signed [SPEED_BITS-1:0] speed_left;
        logic signed [SPEED_BITS-1:0] speed_right;
        logic                         drive_write;
        logic                         following_right;
        logic                         corner_detected;
        logic                         running_led;
        wfd_phase_t                   phase;
    } drive_t;

    typedef struct {
        tick_t  item;
        bit     typed;
        drive_t drive;
    } row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    wfd_in_if  in_ch ();
    wfd_out_if out_ch ();

    wall_following_drive_controller_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // Controller state and register copies
    wfd_phase_t              phase_q;
    logic                    side_q;
    logic                    corner_q;
    logic                    led_q;
    logic [CT_W-1:0]         corner_thr;
    logic [DD_W-1:0]         desired;
    logic [MS_W-1:0]         max_spd;
    logic [MIN_W-1:0]        min_spd;
    logic [ANG_W-1:0]        max_angle;
    logic [AF_W-1:0]         approach;
    logic signed [TG_W-1:0]  turn_gain;
    logic [ST_W-1:0]         stop_thr;

    drive_t      pending_drive_q[$];
    row_t        plan[$];
    int unsigned reg_vals[8];
    int unsigned send_gap_pct;
    int unsigned recv_stall_pct;
    int unsigned cycles;
    int unsigned items_sent;
    int unsigned results_checked;
    int unsigned mismatches;
    int unsigned follow_drives;
    int unsigned corners_hit;
    int unsigned settings_used;

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    function automatic logic signed [SPEED_BITS-1:0] sat_speed(longint v);
        longint hi;
        hi = (longint'(1) <<< (SPEED_BITS - 1)) - 1;
        if (v > hi)
            return SPEED_BITS'(hi);
        if (v < -hi - 1)
            return SPEED_BITS'(-hi - 1);
        return SPEED_BITS'(v);
    endfunction

    // Advance the controller copy by one item and return the drive it produces
    function automatic drive_t predict_drive(tick_t t);
        drive_t                      d;
        logic signed [PROX_BITS-1:0] prox;
        longint                      err;
        longint                      aerr;
        longint                      ang;
        longint                      fwd;
        longint                      turn;
        logic signed [SPEED_BITS-1:0] near_w;
        logic signed [SPEED_BITS-1:0] far_w;
        d.speed_left  = '0;
        d.speed_right = '0;
        d.drive_write = 1'b0;
        case (t.mode)
            MODE_ENTER:
            begin
                led_q   = 1'b1;
                phase_q = PH_START;
            end
            MODE_EXIT:
            begin
                led_q         = 1'b0;
                d.drive_write = 1'b1;
            end
            MODE_TICK:
            begin
                case (phase_q)
                    PH_START:
                    begin
                        // pick the wall on the first positive side reading, tie goes left
                        if (t.left > 0 || t.right > 0)
                        begin
                            side_q        = (t.right > t.left);
                            d.drive_write = 1'b1;
                            phase_q       = PH_FOLLOW;
                        end
                    end
                    PH_FOLLOW:
                    begin
                        if (longint'(t.front) > longint'(corner_thr))
                        begin
                            d.drive_write = 1'b1;
                            phase_q       = PH_STOPPING;
                            corners_hit++;
                        end
                        else
                        begin
                            prox = side_q ? t.front_right : t.front_left;
                            err  = longint'(prox) - longint'(desired);
                            aerr = (err < 0) ? -err : err;
                            ang  = (max_angle == '0) ? 1 : longint'(max_angle);
                            fwd  = (longint'(max_spd) * (ang - aerr)) / ang;
                            if (fwd < longint'(min_spd))
                                fwd = longint'(min_spd);
                            if (fwd > longint'(max_spd))
                                fwd = longint'(max_spd);
                            if (t.tof != '0)
                                fwd = (fwd * longint'(approach)) >>> AF_FRAC;
                            // floor of the product of the Q4.12 gain and the error back to Q8.8
                            turn   = (longint'(turn_gain) * err) >>> TURN_FRAC;
                            near_w = sat_speed(fwd + turn);
                            far_w  = sat_speed(fwd - turn);
                            d.speed_left  = side_q ? far_w : near_w;
                            d.speed_right = side_q ? near_w : far_w;
                            d.drive_write = 1'b1;
                            follow_drives++;
                        end
                    end
                    PH_STOPPING:
                    begin
                        if (longint'(t.meas_left) < longint'(stop_thr) &&
                            longint'(t.meas_right) < longint'(stop_thr))
                        begin
                            corner_q = 1'b1;
                            phase_q  = PH_OFF;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase
        d.following_right = side_q;
        d.corner_detected = corner_q;
        d.running_led     = led_q;
        d.phase           = phase_q;
        return d;
    endfunction

    function automatic tick_t mk_tick(wfd_mode_t m, int pl, int pr, int pf, int pfl, int pfr,
                                      int tof, int ml, int mr);
        tick_t t;
        t.mode        = m;
        t.left        = PROX_BITS'(pl);
        t.right       = PROX_BITS'(pr);
        t.front       = PROX_BITS'(pf);
        t.front_left  = PROX_BITS'(pfl);
        t.front_right = PROX_BITS'(pfr);
        t.tof         = TOF_BITS'(tof);
        t.meas_left   = SPEED_BITS'(ml);
        t.meas_right  = SPEED_BITS'(mr);
        return t;
    endfunction

    function automatic drive_t mk_drive(int sl, int sr, bit wr, bit fr, bit cd, bit led,
                                        wfd_phase_t ph);
        drive_t d;
        d.speed_left      = SPEED_BITS'(sl);
        d.speed_right     = SPEED_BITS'(sr);
        d.drive_write     = wr;
        d.following_right = fr;
        d.corner_detected = cd;
        d.running_led     = led;
        d.phase           = ph;
        return d;
    endfunction

    function automatic void add_row(tick_t t, bit typed, drive_t d);
        row_t r;
        r.item  = t;
        r.typed = typed;
        r.drive = d;
        plan.push_back(r);
    endfunction

    function automatic logic signed [PROX_BITS-1:0] any_prox();
        return PROX_BITS'(int'($urandom_range(2046)) - 1023);
    endfunction

    // Side reading around the target so the forward speed ramps rather than clamps
    function automatic logic signed [PROX_BITS-1:0] near_target();
        int span;
        int v;
        span = int'(max_angle) + 40;
        v    = int'(desired) + int'($urandom_range(2 * span)) - span;
        if (v > 1023)
            v = 1023;
        if (v < -1023)
            v = -1023;
        return PROX_BITS'(v);
    endfunction

    function automatic tick_t gen_tick();
        tick_t       t;
        int unsigned r;
        r = $urandom_range(99);
        if (phase_q == PH_OFF && r < 30)
            t.mode = MODE_ENTER;
        else if (r < 3)
            t.mode = MODE_UNUSED;
        else if (r < 8)
            t.mode = MODE_EXIT;
        else if (r < 12)
            t.mode = MODE_ENTER;
        else
            t.mode = MODE_TICK;
        // side readings: full range, or small values for ties and non-positive pairs
        if ($urandom_range(1))
        begin
            t.left  = any_prox();
            t.right = any_prox();
        end
        else
        begin
            t.left  = PROX_BITS'(int'($urandom_range(12)) - 6);
            t.right = ($urandom_range(3) == 0) ? t.left
                                               : PROX_BITS'(int'($urandom_range(12)) - 6);
        end
        // keep most follow ticks at or below the corner threshold
        if ($urandom_range(99) < 85)
            t.front = PROX_BITS'(int'($urandom_range(int'(corner_thr) + 1023)) - 1023);
        else
            t.front = any_prox();
        t.front_left  = ($urandom_range(99) < 60) ? near_target() : any_prox();
        t.front_right = ($urandom_range(99) < 60) ? near_target() : any_prox();
        case ($urandom_range(3))
            0, 1:    t.tof = '0;
            2:       t.tof = TOF_BITS'($urandom());
            default: t.tof = TOF_BITS'($urandom_range(8191, 1));
        endcase
        if ($urandom_range(1))
        begin
            t.meas_left  = SPEED_BITS'(int'(stop_thr) + int'($urandom_range(8)) - 4);
            t.meas_right = SPEED_BITS'(int'(stop_thr) + int'($urandom_range(8)) - 4);
        end
        else
        begin
            t.meas_left  = SPEED_BITS'($urandom());
            t.meas_right = SPEED_BITS'($urandom());
        end
        return t;
    endfunction

    // Offer one item, hold it until accepted, then queue its expected drive
    task automatic send_tick(input tick_t t, input bit typed, input drive_t typed_drive);
        drive_t predicted;
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid            <= 1'b1;
        in_ch.mode             <= t.mode;
        in_ch.prox_left        <= t.left;
        in_ch.prox_right       <= t.right;
        in_ch.prox_front       <= t.front;
        in_ch.prox_front_left  <= t.front_left;
        in_ch.prox_front_right <= t.front_right;
        in_ch.tof_center       <= t.tof;
        in_ch.measured_left    <= t.meas_left;
        in_ch.measured_right   <= t.meas_right;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        predicted = predict_drive(t);
        pending_drive_q.push_back(typed ? typed_drive : predicted);
        items_sent++;
    endtask

    // Hold off the sender until every drive is back and the block has gone idle
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (pending_drive_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic program_regs();
        for (int i = 0; i < 8; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= CFG_DATA_W'(reg_vals[i]);
            @(posedge clk);
            case (wfd_cfg_idx_t'(i))
                CFG_CORNER_THRESHOLD: corner_thr = CT_W'(reg_vals[i]);
                CFG_DESIRED_DISTANCE: desired    = DD_W'(reg_vals[i]);
                CFG_MAX_SPEED:        max_spd    = MS_W'(reg_vals[i]);
                CFG_MIN_SPEED:        min_spd    = MIN_W'(reg_vals[i]);
                CFG_MAX_SPEED_ANGLE:  max_angle  = ANG_W'(reg_vals[i]);
                CFG_APPROACH_FACTOR:  approach   = AF_W'(reg_vals[i]);
                CFG_TURN_GAIN:        turn_gain  = TG_W'(reg_vals[i]);
                CFG_STOP_THRESHOLD:   stop_thr   = ST_W'(reg_vals[i]);
                default:
                begin
                end
            endcase
        end
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic check_drive();
        drive_t want;
        bit     bad;
        if (pending_drive_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("unexpected drive result at cycle %0d", cycles);
            return;
        end
        want = pending_drive_q.pop_front();
        results_checked++;
        bad = (out_ch.speed_left !== want.speed_left) ||
              (out_ch.speed_right !== want.speed_right) ||
              (out_ch.drive_write !== want.drive_write) ||
              (out_ch.following_right !== want.following_right) ||
              (out_ch.corner_detected !== want.corner_detected) ||
              (out_ch.running_led !== want.running_led) ||
              (out_ch.phase !== want.phase);
        if (bad)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
            begin
                $display("drive mismatch on result %0d at cycle %0d", results_checked, cycles);
                $display("  expected sl=%0d sr=%0d wr=%0b fr=%0b cd=%0b led=%0b ph=%0d",
                         want.speed_left, want.speed_right, want.drive_write,
                         want.following_right, want.corner_detected, want.running_led,
                         want.phase);
                $display("  got      sl=%0d sr=%0d wr=%0b fr=%0b cd=%0b led=%0b ph=%0d",
                         out_ch.speed_left, out_ch.speed_right, out_ch.drive_write,
                         out_ch.following_right, out_ch.corner_detected, out_ch.running_led,
                         out_ch.phase);
            end
        end
    endtask

    // Take results and stall the output at random
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
            check_drive();
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycles, pending_drive_q.size());
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        drive_t no_drive;
        int     n;

        rst_n                  <= 1'b0;
        cfg_we                 <= 1'b0;
        cfg_index              <= CFG_CORNER_THRESHOLD;
        cfg_data               <= '0;
        in_ch.valid            <= 1'b0;
        in_ch.mode             <= MODE_TICK;
        in_ch.prox_left        <= '0;
        in_ch.prox_right       <= '0;
        in_ch.prox_front       <= '0;
        in_ch.prox_front_left  <= '0;
        in_ch.prox_front_right <= '0;
        in_ch.tof_center       <= '0;
        in_ch.measured_left    <= '0;
        in_ch.measured_right   <= '0;

        send_gap_pct    = 20;
        recv_stall_pct  = 45;
        items_sent      = 0;
        results_checked = 0;
        mismatches      = 0;
        follow_drives   = 0;
        corners_hit     = 0;
        settings_used   = 1;

        phase_q    = PH_START;
        side_q     = 1'b0;
        corner_q   = 1'b0;
        led_q      = 1'b0;
        corner_thr = CT_RESET;
        desired    = DD_RESET;
        max_spd    = MS_RESET;
        min_spd    = MIN_RESET;
        max_angle  = ANG_RESET;
        approach   = AF_RESET;
        turn_gain  = TG_RESET;
        stop_thr   = ST_RESET;

        // Directed walk through every phase with the reset settings
        add_row(mk_tick(MODE_TICK, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                mk_drive(0, 0, 0, 0, 0, 0, PH_START));
        add_row(mk_tick(MODE_UNUSED, -1023, 1023, -1023, 1023, -1023, 8191, -32768, 32767), 1,
                mk_drive(0, 0, 0, 0, 0, 0, PH_START));
        add_row(mk_tick(MODE_ENTER, 1023, 1023, 1023, 1023, 1023, 8191, 32767, 32767), 1,
                mk_drive(0, 0, 0, 0, 0, 1, PH_START));
        add_row(mk_tick(MODE_TICK, 5, 5, 0, 300, 300, 0, 0, 0), 1,
                mk_drive(0, 0, 1, 0, 0, 1, PH_FOLLOW));
        add_row(mk_tick(MODE_TICK, 0, 0, 0, 300, 0, 0, 0, 0), 1,
                mk_drive(25600, 25600, 1, 0, 0, 1, PH_FOLLOW));
        add_row(mk_tick(MODE_TICK, 0, 0, -1023, 1023, 0, 8191, 0, 0), 0, no_drive);
        add_row(mk_tick(MODE_TICK, 0, 0, 0, -1023, 0, 1, 0, 0), 0, no_drive);
        add_row(mk_tick(MODE_TICK, 0, 0, 200, 100, 0, 0, 0, 0), 0, no_drive);
        add_row(mk_tick(MODE_TICK, 0, 0, 201, 300, 0, 0, 0, 0), 1,
                mk_drive(0, 0, 1, 0, 0, 1, PH_STOPPING));
        add_row(mk_tick(MODE_TICK, 0, 0, 0, 0, 0, 0, 256, 0), 1,
                mk_drive(0, 0, 0, 0, 0, 1, PH_STOPPING));
        add_row(mk_tick(MODE_TICK, 0, 0, 0, 0, 0, 0, -32768, 32767), 1,
                mk_drive(0, 0, 0, 0, 0, 1, PH_STOPPING));
        add_row(mk_tick(MODE_TICK, 0, 0, 0, 0, 0, 0, 255, -32768), 1,
                mk_drive(0, 0, 0, 0, 1, 1, PH_OFF));
        add_row(mk_tick(MODE_TICK, 1023, 1023, 1023, 300, 300, 8191, 0, 0), 1,
                mk_drive(0, 0, 0, 0, 1, 1, PH_OFF));
        add_row(mk_tick(MODE_EXIT, 7, 9, 11, 13, 15, 17, 19, 21), 1,
                mk_drive(0, 0, 1, 0, 1, 0, PH_OFF));
        add_row(mk_tick(MODE_ENTER, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                mk_drive(0, 0, 0, 0, 1, 1, PH_START));
        add_row(mk_tick(MODE_TICK, -1023, 0, 0, 0, 0, 0, 0, 0), 1,
                mk_drive(0, 0, 0, 0, 1, 1, PH_START));
        add_row(mk_tick(MODE_TICK, 3, 4, 0, 0, 0, 0, 0, 0), 1,
                mk_drive(0, 0, 1, 1, 1, 1, PH_FOLLOW));
        add_row(mk_tick(MODE_TICK, 0, 0, -1023, 0, 1023, 8191, -32768, -32768), 0, no_drive);
        add_row(mk_tick(MODE_TICK, 0, 0, 0, 0, 0, 0, 0, 0), 0, no_drive);
        add_row(mk_tick(MODE_EXIT, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                mk_drive(0, 0, 1, 1, 1, 0, PH_FOLLOW));
        add_row(mk_tick(MODE_TICK, 0, 0, 150, 0, 420, 4096, 0, 0), 0, no_drive);
        add_row(mk_tick(MODE_ENTER, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                mk_drive(0, 0, 0, 1, 1, 1, PH_START));
        add_row(mk_tick(MODE_TICK, 1023, 1023, 0, 0, 0, 0, 0, 0), 1,
                mk_drive(0, 0, 1, 0, 1, 1, PH_FOLLOW));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
            send_tick(plan[i].item, plan[i].typed, plan[i].drive);

        // Random part, one register setting per phase; the first keeps the reset values
        for (int p = 0; p < REG_PHASES; p++)
        begin
            if (p != 0)
            begin
                wait_drained();
                case (p)
                    1: reg_vals = '{1023, 1023, 32767, 32767, 1023, 65535, 32767, 32767};
                    2: reg_vals = '{0, 0, 0, 0, 0, 0, 32'h8000, 0};
                    3: reg_vals = '{600, 512, 1000, 20000, 1, 32768, 32'hFE66, 128};
                    default:
                        reg_vals = '{$urandom_range(1023), $urandom_range(1023),
                                     $urandom_range(32767, 2000), $urandom_range(8000),
                                     $urandom_range(300, 1), $urandom_range(65535),
                                     $urandom_range(65535), $urandom_range(2000)};
                endcase
                program_regs();
            end
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                n = p * PHASE_ITEMS + k;
                if (n < 2 * PHASE_ITEMS)
                begin
                    send_gap_pct   = 20;
                    recv_stall_pct = 45;
                end
                else if (n < 4 * PHASE_ITEMS)
                begin
                    send_gap_pct   = 45;
                    recv_stall_pct = 20;
                end
                else
                begin
                    send_gap_pct   = 0;
                    recv_stall_pct = 0;
                end
                if (k == PHASE_ITEMS / 2)
                    wait_drained();
                send_tick(gen_tick(), 1'b0, no_drive);
            end
        end

        // Drain and let the block settle
        in_ch.valid <= 1'b0;
        while (pending_drive_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d items and %0d checked results over %0d register settings",
                 items_sent, results_checked, settings_used);
        $display("saw %0d driving follow ticks and %0d corner stops, %0d mismatches",
                 follow_drives, corners_hit, mismatches);
        if (mismatches == 0 && pending_drive_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
